// File: rtl/core/wcts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wcts_pkg;

  // Store sizes and the index widths that follow from them.
  localparam int TEXT_DEPTH  = 4096;
  localparam int QUERY_DEPTH = 64;
  localparam int TEXT_AW     = $clog2(TEXT_DEPTH);
  localparam int QUERY_AW    = $clog2(QUERY_DEPTH);
  localparam int TCNT_W      = $clog2(TEXT_DEPTH + 1);
  localparam int QCNT_W      = $clog2(QUERY_DEPTH + 1);

  // Fixed field widths of the stream items.
  localparam int ADDR_W   = 12;
  localparam int BYTE_W   = 8;
  localparam int TLEN_W   = 13;
  localparam int QLEN_W   = 7;
  localparam int CURSOR_W = 13;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 12;

  localparam logic [KIND_W-1:0] KIND_TEXT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;

  localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;

  localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [BYTE_W-1:0] CHAR_LOWER_A = 8'h61;

  typedef struct packed {
    logic              text_we;
    logic              query_we;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
  } wr_req_t;

  typedef struct packed {
    logic [TEXT_AW-1:0]  text_addr;
    logic [QUERY_AW-1:0] query_addr;
  } rd_req_t;

  typedef struct packed {
    logic [BYTE_W-1:0] text_byte;
    logic [BYTE_W-1:0] query_byte;
  } rd_data_t;

  typedef struct packed {
    logic [TLEN_W-1:0]   text_length;
    logic [QLEN_W-1:0]   pattern_len;
    logic [CURSOR_W-1:0] start_cursor;
  } search_cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
  } result_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } scan_stat_t;

  // Folds ASCII upper case letters to lower case; other bytes pass unchanged.
  function automatic logic [BYTE_W-1:0] fold_lower(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] r;
    r = c;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      r = c - CHAR_UPPER_A + CHAR_LOWER_A;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/wrapping_caseless_text_search.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Bits        Contents
// s_axis   in         tdata 56    load bytes and search requests
//                     tuser 2     kind of item
// m_axis   out        tdata 16    match position of a finished search
//                     tuser 2     search status
//
// Load items are accepted back to back. A search compares one text/query
// byte pair a cycle over the candidates it tries; its result then moves from
// the scan's result register into a free output register, and the next input
// is taken once the scan is idle again. An empty or oversized query skips the
// compares and goes straight to its result without reading the stores.
// Input waits while a search runs or its result waits for the output register;
// synchronous reset clears control state and output valid, not the stores.

module wrapping_caseless_text_search (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // addr [11:0], data_byte [19:12], text_length [32:20],
  // pattern_len [39:33], start_cursor [52:40], zeros [55:53]
  input  wire  [55:0] s_axis_tdata,
  // kind [1:0]
  input  wire  [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // match_position [11:0], zeros [15:12]
  output logic [15:0] m_axis_tdata,
  // search_status [1:0]
  output logic [1:0]  m_axis_tuser
);

  wcts_pkg::wr_req_t     wr;
  wcts_pkg::rd_req_t     rd;
  wcts_pkg::rd_data_t    rdata;
  wcts_pkg::search_cmd_t cmd;
  wcts_pkg::result_t     res;
  wcts_pkg::scan_stat_t  stat;

  logic                          in_xfer;
  logic                          start;
  logic                          res_take;
  logic [wcts_pkg::ADDR_W-1:0]   in_addr;

  // Inputs are taken only while no search is running.
  assign s_axis_tready = stat.idle;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  assign in_addr          = s_axis_tdata[11:0];
  assign cmd.text_length  = s_axis_tdata[32:20];
  assign cmd.pattern_len  = s_axis_tdata[39:33];
  assign cmd.start_cursor = s_axis_tdata[52:40];

  // Writes beyond the depth of the addressed store are dropped; an unknown
  // kind is accepted and has no effect.
  assign wr.addr     = in_addr;
  assign wr.data     = s_axis_tdata[19:12];
  assign wr.text_we  = in_xfer && (s_axis_tuser == wcts_pkg::KIND_TEXT) &&
                       (32'(in_addr) < wcts_pkg::TEXT_DEPTH);
  assign wr.query_we = in_xfer && (s_axis_tuser == wcts_pkg::KIND_QUERY) &&
                       (32'(in_addr) < wcts_pkg::QUERY_DEPTH);
  assign start       = in_xfer && (s_axis_tuser == wcts_pkg::KIND_SEARCH);

  // The output register takes a finished result whenever it is empty or its
  // current transfer completes in this cycle.
  assign res_take = stat.res_valid && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_take) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (res_take) begin
      m_axis_tdata <= {4'd0, res.position};
      m_axis_tuser <= res.status;
    end
  end

  wcts_store u_store (
    .clk   (clk),
    .wr    (wr),
    .rd    (rd),
    .rdata (rdata)
  );

  wcts_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .cmd      (cmd),
    .res_take (res_take),
    .rdata    (rdata),
    .rd       (rd),
    .res      (res),
    .stat     (stat)
  );

endmodule

`default_nettype wire

// File: rtl/core/wcts_store.sv
`timescale 1ns / 1ps
`default_nettype none

module wcts_store (
  input  wire                 clk,
  input  wcts_pkg::wr_req_t   wr,
  input  wcts_pkg::rd_req_t   rd,
  output wcts_pkg::rd_data_t  rdata
);

  logic [wcts_pkg::BYTE_W-1:0] text_mem  [wcts_pkg::TEXT_DEPTH];
  logic [wcts_pkg::BYTE_W-1:0] query_mem [wcts_pkg::QUERY_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.text_we) begin
      text_mem[wcts_pkg::TEXT_AW'(wr.addr)] <= wr.data;
    end
    if (wr.query_we) begin
      query_mem[wcts_pkg::QUERY_AW'(wr.addr)] <= wr.data;
    end
    rdata.text_byte  <= text_mem[rd.text_addr];
    rdata.query_byte <= query_mem[rd.query_addr];
  end

endmodule

`default_nettype wire

// File: rtl/core/wcts_scan.sv
`timescale 1ns / 1ps
`default_nettype none

module wcts_scan (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     start,
  input  wcts_pkg::search_cmd_t   cmd,
  input  wire                     res_take,
  input  wcts_pkg::rd_data_t      rdata,
  output wcts_pkg::rd_req_t       rd,
  output wcts_pkg::result_t       res,
  output wcts_pkg::scan_stat_t    stat
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  localparam int TAW = wcts_pkg::TEXT_AW;
  localparam int TCW = wcts_pkg::TCNT_W;
  localparam int QCW = wcts_pkg::QCNT_W;

  logic [1:0]     state, state_next;
  logic [TAW-1:0] pos, pos_next;      // candidate being compared
  logic [TAW-1:0] lim, lim_next;      // last position where the query fits
  logic [QCW-1:0] qlen, qlen_next;
  logic [QCW-1:0] k, k_next;          // next query index to read
  logic [TCW-1:0] rem, rem_next;      // candidates left, this one included
  logic           rv, rv_next;        // a read is in flight
  logic           rlast, rlast_next;  // that read is the last query byte
  wcts_pkg::result_t res_next;

  // Search setup values.
  logic [TCW-1:0] tlen_sat, lim_full, first_pos;
  logic [QCW-1:0] qlen_sat;

  logic           eq, mismatch, hit;
  logic [TAW-1:0] pos_succ;

  always_comb begin
    tlen_sat = (cmd.text_length > wcts_pkg::TLEN_W'(wcts_pkg::TEXT_DEPTH)) ?
               TCW'(wcts_pkg::TEXT_DEPTH) : TCW'(cmd.text_length);
    qlen_sat = (cmd.pattern_len > wcts_pkg::QLEN_W'(wcts_pkg::QUERY_DEPTH)) ?
               QCW'(wcts_pkg::QUERY_DEPTH) : QCW'(cmd.pattern_len);
    lim_full = tlen_sat - TCW'(qlen_sat);
    first_pos = (TCW'(cmd.start_cursor) < tlen_sat && cmd.start_cursor < 
                 wcts_pkg::CURSOR_W'(wcts_pkg::TEXT_DEPTH)) ?
                TCW'(cmd.start_cursor) + TCW'(1) : '0;
    if (first_pos > lim_full) begin
      first_pos = '0;
    end
  end

  assign eq       = wcts_pkg::fold_lower(rdata.text_byte) ==
                    wcts_pkg::fold_lower(rdata.query_byte);
  assign mismatch = rv && !eq;
  assign hit      = rv && eq && rlast;
  assign pos_succ = (pos == lim) ? '0 : pos + TAW'(1);

  always_comb begin
    state_next = state;
    pos_next   = pos;
    lim_next   = lim;
    qlen_next  = qlen;
    k_next     = k;
    rem_next   = rem;
    rv_next    = 1'b0;
    rlast_next = rlast;
    res_next   = res;
    rd.text_addr  = pos + TAW'(k);
    rd.query_addr = wcts_pkg::QUERY_AW'(k);

    case (state)
      S_IDLE: begin
        if (start) begin
          res_next.position = '0;
          if (qlen_sat == '0) begin
            res_next.status = wcts_pkg::ST_EMPTY;
            state_next      = S_DONE;
          end else if (TCW'(qlen_sat) > tlen_sat) begin
            res_next.status = wcts_pkg::ST_NOT_FOUND;
            state_next      = S_DONE;
          end else begin
            pos_next   = TAW'(first_pos);
            lim_next   = TAW'(lim_full);
            qlen_next  = qlen_sat;
            k_next     = '0;
            rem_next   = lim_full + TCW'(1);
            state_next = S_RUN;
          end
        end
      end
      S_RUN: begin
        if (hit) begin
          res_next.status   = wcts_pkg::ST_FOUND;
          res_next.position = wcts_pkg::POS_W'(pos);
          state_next        = S_DONE;
        end else if (mismatch) begin
          if (rem == TCW'(1)) begin
            res_next.status   = wcts_pkg::ST_NOT_FOUND;
            res_next.position = '0;
            state_next        = S_DONE;
          end else begin
            // Start the next candidate right away with its first byte.
            rd.text_addr  = pos_succ;
            rd.query_addr = '0;
            pos_next      = pos_succ;
            rem_next      = rem - TCW'(1);
            k_next        = QCW'(1);
            rv_next       = 1'b1;
            rlast_next    = (qlen == QCW'(1));
          end
        end else if (k != qlen) begin
          rv_next    = 1'b1;
          rlast_next = (k == qlen - QCW'(1));
          k_next     = k + QCW'(1);
        end
      end
      S_DONE: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rv    <= 1'b0;
    end else begin
      state <= state_next;
      rv    <= rv_next;
    end
    pos   <= pos_next;
    lim   <= lim_next;
    qlen  <= qlen_next;
    k     <= k_next;
    rem   <= rem_next;
    rlast <= rlast_next;
    res   <= res_next;
  end

  assign stat.idle      = (state == S_IDLE);
  assign stat.res_valid = (state == S_DONE);

endmodule

`default_nettype wire

// File: sim/wrapping_caseless_text_search_test.sv
`timescale 1ns / 1ps

module wrapping_caseless_text_search_test;
  import wcts_pkg::*;

  // Kind code 3 has no meaning in the block; such transfers must be dropped.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // Character mixes used when text is generated.
  localparam int ALPHA_AB      = 0;
  localparam int ALPHA_LETTERS = 1;
  localparam int ALPHA_ANY     = 2;

  localparam int DIRECTED_ITEMS = 25;
  localparam int RANDOM_ITEMS   = 1600;
  localparam int TAIL_TEXT      = 128;
  localparam int LONG_HOLD      = 2000;
  localparam int DRAIN_CYCLES   = 20;

  // The ten bytes of text used by the directed searches, byte 0 lowest:
  // "xAbZ@[aB", then 0xFF and 0x00.
  localparam logic [79:0] SAMPLE_TEXT = {8'h00, 8'hFF, 8'h42, 8'h61, 8'h5B,
                                         8'h40, 8'h5A, 8'h62, 8'h41, 8'h78};

  // One input transfer before packing onto the bus.
  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [ADDR_W-1:0]   addr;
    logic [BYTE_W-1:0]   data;
    logic [TLEN_W-1:0]   text_length;
    logic [QLEN_W-1:0]   pattern_len;
    logic [CURSOR_W-1:0] start_cursor;
  } load_or_search_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // addr [11:0], data_byte [19:12], text_length [32:20],
  // pattern_len [39:33], start_cursor [52:40], zeros [55:53]
  logic [55:0] s_axis_tdata = '0;
  // kind [1:0]
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // match_position [11:0], zeros [15:12]
  logic [15:0] m_axis_tdata;
  // search_status [1:0]
  logic [1:0]  m_axis_tuser;

  wrapping_caseless_text_search u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Transfers waiting to be offered, and search answers still owed by the block.
  load_or_search_t pending_loads[$];
  result_t         answers_due[$];

  // Our own copy of the two stores, updated as each transfer is accepted.
  logic [BYTE_W-1:0] text_copy [TEXT_DEPTH];
  logic [BYTE_W-1:0] query_copy [QUERY_DEPTH];

  // What the stimulus generator has planned to write so far. A search may only
  // cover the written prefix of the text store, so that prefix is tracked;
  // query lengths come from the query bytes just written.
  logic [BYTE_W-1:0] planned_text [TEXT_DEPTH];
  bit                planned_text_ok [TEXT_DEPTH];
  int                text_ready;
  int                useful_items;

  // Upper bound of the run in cycles, built up while the stimulus is made.
  longint work_bound;
  longint cycle_limit = 64'd100_000_000;
  longint cycle_count = 0;

  int     error_count  = 0;
  int     results_seen = 0;
  bit     in_took;
  bit     rx_hold = 1'b0;
  int     tx_burst_left = 0;
  int     tx_gap_left   = 0;
  int     rx_mode       = 0;
  int     rx_left       = 0;
  int     rx_tick       = 0;

  load_or_search_t taken_item;
  result_t         due_result;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ASCII upper case folds onto lower case; every other byte stands as it is.
  function automatic logic [BYTE_W-1:0] lower_letter(input logic [BYTE_W-1:0] b);
    return (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) ? (b | 8'h20) : b;
  endfunction

  // True when the query, ql bytes long, sits in the text copy at position p.
  function automatic bit window_matches(input int p, input int ql);
    bit same;
    same = 1'b1;
    for (int k = 0; k < ql && same; k++) begin
      if (lower_letter(text_copy[p + k]) != lower_letter(query_copy[k])) begin
        same = 1'b0;
      end
    end
    return same;
  endfunction

  // Works out the answer to one search against the current store copies. The
  // scan order is the cursor's successor up to the end, then from 0 back to it,
  // which is a walk over all text positions starting at that successor.
  function automatic result_t find_match(input load_or_search_t it);
    int      tl;
    int      ql;
    int      first;
    int      p;
    result_t r;
    tl = (it.text_length > TEXT_DEPTH) ? TEXT_DEPTH : int'(it.text_length);
    ql = (it.pattern_len > QUERY_DEPTH) ? QUERY_DEPTH : int'(it.pattern_len);
    r.status   = ST_NOT_FOUND;
    r.position = '0;
    if (ql == 0) begin
      r.status = ST_EMPTY;
    end else if (ql <= tl) begin
      first = (it.start_cursor < tl) ? int'(it.start_cursor) + 1 : 0;
      for (int n = 0; n < tl && r.status != ST_FOUND; n++) begin
        p = (first + n) % tl;
        if (p + ql <= tl && window_matches(p, ql)) begin
          r.status   = ST_FOUND;
          r.position = p[POS_W-1:0];
        end
      end
    end
    return r;
  endfunction

  function automatic logic [BYTE_W-1:0] pick_byte(input int mix);
    logic [BYTE_W-1:0] b;
    case (mix)
      ALPHA_AB:      b = CHAR_UPPER_A + BYTE_W'($urandom_range(0, 1));
      ALPHA_LETTERS: b = CHAR_UPPER_A + BYTE_W'($urandom_range(0, 25));
      default:       b = BYTE_W'($urandom_range(0, 255));
    endcase
    if (mix != ALPHA_ANY && $urandom_range(0, 1) == 1) begin
      b = b | 8'h20;
    end
    return b;
  endfunction

  // Letters get their case flipped at random; other bytes are left alone so
  // that a query copied from the text still matches it.
  function automatic logic [BYTE_W-1:0] flip_case(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] low;
    low = lower_letter(b);
    if (low >= CHAR_LOWER_A && low <= CHAR_LOWER_A + 25 && $urandom_range(0, 1) == 1) begin
      return b ^ 8'h20;
    end
    return b;
  endfunction

  // Queues a store write (or an item of the unused kind). The search fields
  // carry random values since the block must ignore them here.
  task automatic queue_write(input logic [KIND_W-1:0] kind, input int addr,
                             input logic [BYTE_W-1:0] value);
    load_or_search_t it;
    it.kind         = kind;
    it.addr         = ADDR_W'(addr);
    it.data         = value;
    it.text_length  = TLEN_W'($urandom);
    it.pattern_len  = QLEN_W'($urandom);
    it.start_cursor = CURSOR_W'($urandom);
    pending_loads.push_back(it);
    work_bound += 20;
    if (kind == KIND_TEXT) begin
      planned_text[it.addr]    = value;
      planned_text_ok[it.addr] = 1'b1;
      while (text_ready < TEXT_DEPTH && planned_text_ok[text_ready]) text_ready++;
    end
    if (kind != KIND_UNUSED) useful_items++;
  endtask

  // Queues a search. Callers only pick lengths that stay within what has been
  // written, or that make the block answer without reading the stores, or
  // that put a match ahead of any unwritten text in scan order.
  task automatic queue_search(input int tl, input int ql, input int cur);
    load_or_search_t it;
    longint          tl_eff;
    longint          ql_eff;
    it.kind         = KIND_SEARCH;
    it.addr         = ADDR_W'($urandom);
    it.data         = BYTE_W'($urandom);
    it.text_length  = TLEN_W'(tl);
    it.pattern_len  = QLEN_W'(ql);
    it.start_cursor = CURSOR_W'(cur);
    pending_loads.push_back(it);
    tl_eff = (tl > TEXT_DEPTH) ? TEXT_DEPTH : tl;
    ql_eff = (ql > QUERY_DEPTH) ? QUERY_DEPTH : ql;
    work_bound += 100 + tl_eff * ql_eff;
    useful_items++;
  endtask

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= 10) $display("Mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  // Stimulus, reset and the end of the run.
  initial begin
    int len;
    int qn;
    int src;
    int tl;
    int ql;
    int cur;
    int pick;
    int mix;
    int reps;
    text_ready   = 0;
    useful_items = 0;
    work_bound   = 0;

    // Directed part. With both stores still empty, only the cases that read
    // nothing are allowed: an empty query and a query longer than the text.
    queue_search(8191, 0, 8191);
    queue_search(0, 0, 0);
    queue_search(5, 127, 0);
    queue_write(KIND_UNUSED, 4095, 8'hFF);
    // The query store is far smaller than the address range; this is dropped.
    queue_write(KIND_QUERY, 4095, 8'h00);
    for (int k = 0; k < 10; k++) queue_write(KIND_TEXT, k, SAMPLE_TEXT[8*k +: 8]);
    queue_write(KIND_QUERY, 0, CHAR_LOWER_A);
    queue_write(KIND_QUERY, 1, 8'h42);
    // The query "aB" hits mixed case text both just after the cursor and
    // further on; the cursor on the last byte and past the end both wrap.
    queue_search(10, 2, 0);
    queue_search(10, 2, 1);
    queue_search(10, 2, 9);
    queue_search(10, 2, 10);
    // Text exactly as long as the query, then text one byte too short.
    queue_search(2, 2, 0);
    queue_search(1, 2, 0);
    // A top-valued byte in the query must match the same byte in the text.
    queue_write(KIND_QUERY, 2, 8'hFF);
    queue_search(10, 3, 3);

    // Random part. Most of it loads a text, loads a query that is often a
    // case-shuffled piece of that text, and searches it from various cursors.
    while (useful_items < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(49, 300) : $urandom_range(1, 48);
        mix = $urandom_range(ALPHA_AB, ALPHA_ANY);
        for (int k = 0; k < len; k++) queue_write(KIND_TEXT, k, pick_byte(mix));
        if ($urandom_range(0, 4) == 0) begin
          qn = $urandom_range(1, (len < QUERY_DEPTH) ? len : QUERY_DEPTH);
        end else begin
          qn = $urandom_range(1, (len < 6) ? len : 6);
        end
        src = $urandom_range(0, len - qn);
        // The query goes in from the top down; a few bytes are spoiled so
        // that near misses show up too.
        for (int k = qn - 1; k >= 0; k--) begin
          queue_write(KIND_QUERY, k, ($urandom_range(0, 3) == 0) ? pick_byte(mix) :
                                                                   flip_case(planned_text[src + k]));
        end
        reps = $urandom_range(1, 5);
        for (int n = 0; n < reps; n++) begin
          case ($urandom_range(0, 9))
            0, 1: tl = $urandom_range(qn, (text_ready < len + 100) ? text_ready : len + 100);
            2:    tl = $urandom_range(0, qn - 1);
            default: tl = len;
          endcase
          ql = (qn == QUERY_DEPTH) ? $urandom_range(QUERY_DEPTH, 127) : qn;
          case ($urandom_range(0, 5))
            0: cur = (tl > 0) ? tl - 1 : 0;
            1: cur = tl + $urandom_range(0, 2);
            2: cur = $urandom_range(0, 8191);
            default: cur = $urandom_range(0, (tl > 0) ? tl - 1 : 0);
          endcase
          queue_search(tl, ql, cur);
        end
      end else if (pick < 85) begin
        // Stray writes anywhere in the address range of either store.
        reps = $urandom_range(1, 6);
        for (int n = 0; n < reps; n++) begin
          queue_write($urandom_range(0, 1) ? KIND_QUERY : KIND_TEXT, $urandom_range(0, 4095),
                      BYTE_W'($urandom_range(0, 255)));
        end
      end else if (pick < 90) begin
        queue_search($urandom_range(0, 8191), 0, $urandom_range(0, 8191));
      end else if (pick < 95) begin
        // A query, after saturation, longer than the text.
        ql = $urandom_range(1, 127);
        tl = $urandom_range(0, ((ql < QUERY_DEPTH) ? ql : QUERY_DEPTH) - 1);
        queue_search(tl, ql, $urandom_range(0, 8191));
      end else begin
        reps = $urandom_range(1, 3);
        for (int n = 0; n < reps; n++) begin
          queue_write(KIND_UNUSED, $urandom_range(0, 4095), BYTE_W'($urandom_range(0, 255)));
        end
      end
    end

    // Searches with lengths at and beyond the store sizes, which must
    // saturate. Only the start of the text is loaded, so each query is a copy
    // of text that the scan reaches before it could leave the loaded part.
    for (int k = 0; k < TAIL_TEXT; k++) begin
      queue_write(KIND_TEXT, k, pick_byte(($urandom_range(0, 3) == 0) ? ALPHA_LETTERS : ALPHA_ANY));
    end
    for (int k = 0; k < QUERY_DEPTH; k++) begin
      queue_write(KIND_QUERY, k, flip_case(planned_text[k]));
    end
    queue_search(TEXT_DEPTH, QUERY_DEPTH, TEXT_DEPTH - 1);
    queue_search(8191, 127, 8191);
    queue_search(5000, 100, TEXT_DEPTH);
    for (int k = 0; k < 3; k++) queue_write(KIND_QUERY, k, flip_case(planned_text[100 + k]));
    queue_search(TEXT_DEPTH, 3, 99);
    queue_search(6000, 3, 99);
    queue_search(8191, 3, 8191);

    cycle_limit = 4 * work_bound + 50_000;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (pending_loads.size() != 0 || answers_due.size() != 0) @(posedge clk);
    // A trailing write causes no answer; give the block time to show any
    // stray result before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Sender: bursts of random length with random gaps. An offered transfer is
  // held steady until the block takes it, and only then is the next chosen.
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_took) begin
      if (tx_gap_left > 0) begin
        tx_gap_left = tx_gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_loads.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= pending_loads[0].kind;
        s_axis_tdata  <= {3'b000, pending_loads[0].start_cursor, pending_loads[0].pattern_len,
                          pending_loads[0].text_length, pending_loads[0].data,
                          pending_loads[0].addr};
        if (tx_burst_left <= 1) begin
          tx_burst_left = $urandom_range(1, 40);
          // A quarter of the bursts run straight into the next one.
          tx_gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          tx_burst_left = tx_burst_left - 1;
        end
      end
    end
  end

  // Input side: each accepted transfer is decoded from the bus itself and
  // applied to the store copies; a search adds its answer to the queue.
  always @(posedge clk) begin
    if (rst) begin
      in_took <= 1'b0;
    end else begin
      in_took <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        taken_item.kind         = s_axis_tuser;
        taken_item.addr         = s_axis_tdata[11:0];
        taken_item.data         = s_axis_tdata[19:12];
        taken_item.text_length  = s_axis_tdata[32:20];
        taken_item.pattern_len  = s_axis_tdata[39:33];
        taken_item.start_cursor = s_axis_tdata[52:40];
        void'(pending_loads.pop_front());
        case (taken_item.kind)
          KIND_TEXT:   text_copy[taken_item.addr] = taken_item.data;
          KIND_QUERY: begin
            if (taken_item.addr < QUERY_DEPTH) query_copy[taken_item.addr] = taken_item.data;
          end
          KIND_SEARCH: answers_due.push_back(find_match(taken_item));
          default: ;
        endcase
      end
    end
  end

  // Receiver: it switches every so often between always ready, coin flips,
  // one cycle in four, and long stall runs. The long hold-off overrides all.
  always @(negedge clk) begin
    rx_tick = rx_tick + 1;
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(20, 300);
    end else begin
      rx_left = rx_left - 1;
    end
    case (rx_mode)
      0:       m_axis_tready <= !rx_hold;
      1:       m_axis_tready <= !rx_hold && ($urandom_range(0, 1) == 1);
      2:       m_axis_tready <= !rx_hold && (rx_tick % 4 == 0);
      default: m_axis_tready <= !rx_hold && (rx_tick % 40 >= 30);
    endcase
  end

  // Once the run is under way the receiver stops taking results for a long
  // stretch, while the sender keeps offering, so that a finished result fills
  // the output register, the next search waits behind it and the input backs up.
  initial begin
    wait (results_seen >= 40);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // Monitor: each result transfer is checked against the oldest answer due.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (answers_due.size() == 0) begin
        report_mismatch($sformatf("result with none due: status %0d position %0d",
                                  m_axis_tuser, m_axis_tdata[POS_W-1:0]));
      end else begin
        due_result = answers_due.pop_front();
        if (m_axis_tuser !== due_result.status ||
            m_axis_tdata[POS_W-1:0] !== due_result.position) begin
          report_mismatch($sformatf("expected status %0d position %0d, got status %0d position %0d",
                                    due_result.status, due_result.position,
                                    m_axis_tuser, m_axis_tdata[POS_W-1:0]));
        end
      end
    end
  end

  // Watchdog against a hung block.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > cycle_limit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule

// File: wrapping_caseless_text_search.f
rtl/core/wcts_pkg.sv
rtl/core/wcts_store.sv
rtl/core/wcts_scan.sv
rtl/core/wrapping_caseless_text_search.sv
sim/wrapping_caseless_text_search_test.sv
